// ----- rtl/dbp_pkg.sv -----
// Package for the decimal big-integer power core.
// Holds transaction payload types and shared sizing constants; no dependencies.
package dbp_pkg;

	localparam int MAX_DIGITS_DEF = 128;
	localparam int BASE_DIGITS    = 10;

	typedef struct packed {
		logic [30:0] base;
		logic [15:0] exponent;
	} in_t;

	typedef struct packed {
		logic [15:0] bcd_group;
		logic [2:0]  digits_valid;
		logic        last;
		logic        overflow;
	} out_t;

endpackage

// ----- rtl/decimal_bignum_power_core.sv -----
// Decimal big-integer power core: base^exponent as BCD groups, MSD first.
// Depends on dbp_pkg (payload types, size defaults).
//
// One transaction is taken at a time. The base is converted to decimal with
// one shift-add-3 step per cycle, then 16 squarings and one multiply by the
// base per set exponent bit run on a single digit multiply-accumulate that
// reads two digits of the accumulator memory per cycle. Each product sweeps
// all MAX_DIGITS columns (init, multiply-accumulate, divide by ten) and then
// copies the product back into the accumulator. Output reads the result one
// digit at a time and holds each BCD group until it is taken.
// With 128 digits, the fixed 128-column pass and copy-back of each of up to
// 32 products set most of the run time of a full-size result. Exponent zero
// gives 1, base zero with a nonzero exponent gives 0; both present their
// result the cycle after the transaction is accepted.
module decimal_bignum_power_core #(
	parameter int MAX_DIGITS = dbp_pkg::MAX_DIGITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dbp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dbp_pkg::out_t out_data
);

	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int LEN_W = $clog2(MAX_DIGITS + 1);
	localparam int SUM_W = $clog2(MAX_DIGITS * 90 + 10);
	localparam int DIV_S = SUM_W + 4;
	localparam int DIV_M = ((1 << DIV_S) + 9) / 10;
	localparam int PRD_W = SUM_W + DIV_S;
	localparam int BCD_W = 4 * dbp_pkg::BASE_DIGITS;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CONV   = 4'd1;
	localparam logic [3:0] ST_NBASE  = 4'd2;
	localparam logic [3:0] ST_MSTART = 4'd3;
	localparam logic [3:0] ST_CINIT  = 4'd4;
	localparam logic [3:0] ST_MAC    = 4'd5;
	localparam logic [3:0] ST_DIV1   = 4'd6;
	localparam logic [3:0] ST_DIV2   = 4'd7;
	localparam logic [3:0] ST_CHECK  = 4'd8;
	localparam logic [3:0] ST_COPY   = 4'd9;
	localparam logic [3:0] ST_NEXT   = 4'd10;
	localparam logic [3:0] ST_ERD    = 4'd11;
	localparam logic [3:0] ST_EGET   = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;

	logic [3:0]       state_q;
	logic [30:0]      shreg_q;
	logic [4:0]       conv_cnt_q;
	logic [BCD_W-1:0] base_bcd_q;
	logic [3:0]       nbase_q;
	logic [15:0]      exp_q;
	logic [3:0]       bit_q;
	logic             mode_sq_q;
	logic [LEN_W-1:0] na_q, nb_q, k_q, i_q, hi_q, len_q, c_q, pos_q;
	logic [SUM_W-1:0] sum_q, carry_q, quo_q;
	logic [15:0]      val_q;
	logic [2:0]       cnt_q;
	dbp_pkg::out_t    out_q;

	logic [3:0] acc_mem [MAX_DIGITS];
	logic [3:0] prod_mem [MAX_DIGITS];
	logic [3:0] acc_a_s1, acc_b_s1, base_s1, prod_s1;
	logic       rdv_s1, cpv_s1;
	logic [IDX_W-1:0] cpa_s1;

	logic [IDX_W-1:0] acc_ra, acc_rb, acc_wa;
	logic             acc_we;
	logic [3:0]       acc_wd;
	logic [LEN_W-1:0] diff;
	logic [BCD_W-1:0] bcd_adj;
	logic [3:0]       nbase_c;
	logic [LEN_W:0]   kp1;
	logic [LEN_W-1:0] lo_c, hi_c, na_m1;
	logic [PRD_W-1:0] div_prod;
	logic [SUM_W+3:0] quo_x10;
	logic [SUM_W-1:0] rem_c;
	logic [3:0]       digit_c;
	logic [7:0]       mac_prod;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;

	assign diff   = k_q - i_q;
	assign acc_ra = (state_q == ST_MAC) ? i_q[IDX_W-1:0] : pos_q[IDX_W-1:0];
	assign acc_rb = diff[IDX_W-1:0];
	assign acc_we = (state_q == ST_NBASE) || ((state_q == ST_COPY) && cpv_s1);
	assign acc_wa = (state_q == ST_NBASE) ? '0 : cpa_s1;
	assign acc_wd = (state_q == ST_NBASE) ? 4'd1 : prod_s1;

	always_comb begin
		for (int d = 0; d < dbp_pkg::BASE_DIGITS; d++) begin
			if (base_bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = base_bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = base_bcd_q[4*d +: 4];
			end
		end
	end

	always_comb begin
		nbase_c = 4'd1;
		for (int d = 0; d < dbp_pkg::BASE_DIGITS; d++) begin
			if (base_bcd_q[4*d +: 4] != 4'd0) begin
				nbase_c = 4'(d + 1);
			end
		end
	end

	assign kp1     = {1'b0, k_q} + (LEN_W+1)'(1);
	assign lo_c    = (kp1 > {1'b0, nb_q}) ? LEN_W'(kp1 - {1'b0, nb_q}) : '0;
	assign na_m1   = na_q - LEN_W'(1);
	assign hi_c    = (k_q < na_m1) ? k_q : na_m1;
	assign div_prod = PRD_W'(sum_q) * PRD_W'(DIV_M);
	assign quo_x10 = ((SUM_W+4)'(quo_q) << 3) + ((SUM_W+4)'(quo_q) << 1);
	assign rem_c   = sum_q - quo_x10[SUM_W-1:0];
	assign digit_c = rem_c[3:0];
	assign mac_prod = acc_a_s1 * (mode_sq_q ? acc_b_s1 : base_s1);

	// Memories and their registered reads.
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		if (state_q == ST_DIV2) begin
			prod_mem[k_q[IDX_W-1:0]] <= digit_c;
		end
		acc_a_s1 <= acc_mem[acc_ra];
		acc_b_s1 <= acc_mem[acc_rb];
		prod_s1  <= prod_mem[c_q[IDX_W-1:0]];
		if (diff < LEN_W'(dbp_pkg::BASE_DIGITS)) begin
			base_s1 <= base_bcd_q[4*diff[3:0] +: 4];
		end else begin
			base_s1 <= 4'd0;
		end
		cpa_s1 <= c_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdv_s1  <= 1'b0;
			cpv_s1  <= 1'b0;
			na_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						exp_q <= in_data.exponent;
						if (in_data.exponent == 16'd0) begin
							out_q   <= '{bcd_group: 16'd1, digits_valid: 3'd1, last: 1'b1,
								overflow: 1'b0};
							state_q <= ST_OUT;
						end else if (in_data.base == 31'd0) begin
							out_q   <= '{bcd_group: 16'd0, digits_valid: 3'd1, last: 1'b1,
								overflow: 1'b0};
							state_q <= ST_OUT;
						end else begin
							shreg_q    <= in_data.base;
							base_bcd_q <= '0;
							conv_cnt_q <= 5'd0;
							state_q    <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					base_bcd_q <= {bcd_adj[BCD_W-2:0], shreg_q[30]};
					shreg_q    <= {shreg_q[29:0], 1'b0};
					conv_cnt_q <= conv_cnt_q + 5'd1;
					if (conv_cnt_q == 5'd30) begin
						state_q <= ST_NBASE;
					end
				end
				ST_NBASE: begin
					nbase_q   <= nbase_c;
					na_q      <= LEN_W'(1);
					bit_q     <= 4'd15;
					mode_sq_q <= 1'b1;
					state_q   <= ST_MSTART;
				end
				ST_MSTART: begin
					if (({1'b0, na_q} + (LEN_W+1)'(mode_sq_q ? na_q : LEN_W'(nbase_q)))
						> (LEN_W+1)'(MAX_DIGITS + 1)) begin
						out_q   <= '{bcd_group: 16'd0, digits_valid: 3'd1, last: 1'b1,
							overflow: 1'b1};
						state_q <= ST_OUT;
					end else begin
						nb_q    <= mode_sq_q ? na_q : LEN_W'(nbase_q);
						k_q     <= '0;
						carry_q <= '0;
						len_q   <= LEN_W'(1);
						state_q <= ST_CINIT;
					end
				end
				ST_CINIT: begin
					sum_q <= carry_q;
					i_q   <= lo_c;
					hi_q  <= hi_c;
					state_q <= (lo_c <= hi_c) ? ST_MAC : ST_DIV1;
				end
				ST_MAC: begin
					if (rdv_s1) begin
						sum_q <= sum_q + SUM_W'(mac_prod);
					end
					if (i_q <= hi_q) begin
						i_q    <= i_q + LEN_W'(1);
						rdv_s1 <= 1'b1;
					end else begin
						rdv_s1 <= 1'b0;
						if (!rdv_s1) begin
							state_q <= ST_DIV1;
						end
					end
				end
				ST_DIV1: begin
					quo_q   <= div_prod[PRD_W-1:DIV_S];
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					carry_q <= quo_q;
					if (digit_c != 4'd0) begin
						len_q <= k_q + LEN_W'(1);
					end
					if (k_q == LEN_W'(MAX_DIGITS - 1)) begin
						state_q <= ST_CHECK;
					end else begin
						k_q     <= k_q + LEN_W'(1);
						state_q <= ST_CINIT;
					end
				end
				ST_CHECK: begin
					if (carry_q != '0) begin
						out_q   <= '{bcd_group: 16'd0, digits_valid: 3'd1, last: 1'b1,
							overflow: 1'b1};
						state_q <= ST_OUT;
					end else begin
						na_q    <= len_q;
						c_q     <= '0;
						cpv_s1  <= 1'b0;
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (c_q < LEN_W'(MAX_DIGITS)) begin
						c_q    <= c_q + LEN_W'(1);
						cpv_s1 <= 1'b1;
					end else begin
						cpv_s1 <= 1'b0;
						if (!cpv_s1) begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (mode_sq_q && exp_q[bit_q]) begin
						mode_sq_q <= 1'b0;
						state_q   <= ST_MSTART;
					end else if (bit_q == 4'd0) begin
						pos_q   <= na_m1;
						val_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_ERD;
					end else begin
						bit_q     <= bit_q - 4'd1;
						mode_sq_q <= 1'b1;
						state_q   <= ST_MSTART;
					end
				end
				ST_ERD: begin
					state_q <= ST_EGET;
				end
				ST_EGET: begin
					if (pos_q[1:0] == 2'd0) begin
						out_q <= '{bcd_group: {val_q[11:0], acc_a_s1},
							digits_valid: cnt_q + 3'd1, last: (pos_q == '0), overflow: 1'b0};
						state_q <= ST_OUT;
					end else begin
						val_q   <= {val_q[11:0], acc_a_s1};
						cnt_q   <= cnt_q + 3'd1;
						pos_q   <= pos_q - LEN_W'(1);
						state_q <= ST_ERD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (out_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							val_q   <= '0;
							cnt_q   <= '0;
							pos_q   <= pos_q - LEN_W'(1);
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=> in_ready)
		else $error("last transaction did not return to idle");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MSTART) |-> (na_q != '0) && (na_q <= LEN_W'(MAX_DIGITS)))
		else $error("accumulator length out of range");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

endmodule

// ----- test/decimal_bignum_power_core_tb.sv -----
// Testbench for decimal_bignum_power_core: directed and random base/exponent pairs,
// checked group by group against an in-bench decimal power predictor.
// Depends on dbp_pkg and the core RTL.
module decimal_bignum_power_core_tb;

	localparam int NDIG = dbp_pkg::MAX_DIGITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	dbp_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	dbp_pkg::out_t out_data;

	dbp_pkg::out_t group_q[$];
	int fail_count;
	int idle_cycles;
	bit calm;

	int acc[NDIG];
	int prod[NDIG];
	int bdig[dbp_pkg::BASE_DIGITS];

	decimal_bignum_power_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// prod = acc * (acc or base digits); 0 on overflow
	function automatic int mul_digits(int na, int nb, bit square);
		int carry, len, s, lo, hi;
		carry = 0;
		len = 1;
		if (na + nb - 1 > NDIG)
			return 0;
		for (int k = 0; k < NDIG; k++) begin
			s = carry;
			lo = (k + 1 > nb) ? k + 1 - nb : 0;
			hi = (k < na - 1) ? k : na - 1;
			for (int i = lo; i <= hi && i < na; i++)
				s += acc[i] * (square ? acc[k - i] : bdig[k - i]);
			prod[k] = s % 10;
			carry = s / 10;
			if (prod[k] != 0)
				len = k + 1;
		end
		if (carry != 0)
			return 0;
		return len;
	endfunction

	// returns digit count, 0 on overflow
	function automatic int power_digits(logic [30:0] b, logic [15:0] e);
		int nb, na, n;
		longint unsigned v;
		nb = 0;
		na = 1;
		v = b;
		foreach (acc[i]) acc[i] = 0;
		foreach (bdig[i]) bdig[i] = 0;
		if (e == 0) begin
			acc[0] = 1;
			return 1;
		end
		if (b == 0)
			return 1;
		while (v > 0 && nb < dbp_pkg::BASE_DIGITS) begin
			bdig[nb] = int'(v % 10);
			nb = nb + 1;
			v = v / 10;
		end
		acc[0] = 1;
		for (int bit_i = 15; bit_i >= 0; bit_i--) begin
			n = mul_digits(na, na, 1'b1);
			if (n == 0)
				return 0;
			acc = prod;
			na = n;
			if (e[bit_i]) begin
				n = mul_digits(na, nb, 1'b0);
				if (n == 0)
					return 0;
				acc = prod;
				na = n;
			end
		end
		return na;
	endfunction

	task automatic predict_groups(dbp_pkg::in_t item);
		int nd, groups, first, pos, cnt;
		dbp_pkg::out_t g;
		nd = power_digits(item.base, item.exponent);
		if (nd == 0) begin
			g = '{bcd_group: 16'h0, digits_valid: 3'd1, last: 1'b1, overflow: 1'b1};
			group_q.push_back(g);
		end else begin
			groups = (nd + 3) / 4;
			first = nd - 4 * (groups - 1);
			pos = nd;
			for (int q = 0; q < groups; q++) begin
				cnt = (q == 0) ? first : 4;
				g = '0;
				for (int d = 0; d < cnt; d++) begin
					pos--;
					g.bcd_group = {g.bcd_group[11:0], 4'(acc[pos])};
				end
				g.digits_valid = 3'(cnt);
				g.last = (q + 1 == groups);
				group_q.push_back(g);
			end
		end
	endtask

	task automatic send_item(logic [30:0] b, logic [15:0] e);
		dbp_pkg::in_t item;
		item.base = b;
		item.exponent = e;
		if (!calm && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		predict_groups(item);
	endtask

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (group_q.size() == 0) begin
				$error("unexpected result transaction %h", out_data);
				fail_count++;
			end else begin
				if (out_data.bcd_group !== group_q[0].bcd_group) begin
					$error("bcd_group exp %h got %h", group_q[0].bcd_group, out_data.bcd_group);
					fail_count++;
				end
				if (out_data.digits_valid !== group_q[0].digits_valid) begin
					$error("digits_valid exp %0d got %0d", group_q[0].digits_valid,
						out_data.digits_valid);
					fail_count++;
				end
				if (out_data.last !== group_q[0].last) begin
					$error("last exp %0d got %0d", group_q[0].last, out_data.last);
					fail_count++;
				end
				if (out_data.overflow !== group_q[0].overflow) begin
					$error("overflow exp %0d got %0d", group_q[0].overflow, out_data.overflow);
					fail_count++;
				end
				void'(group_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("FAIL decimal_bignum_power_core");
			$finish;
		end
	end

	task automatic test_special_cases();
		send_item(31'd0, 16'd0);
		send_item(31'd0, 16'd5);
		send_item(31'd0, 16'hFFFF);
		send_item(31'd5, 16'd0);
		send_item(31'h7FFFFFFF, 16'd0);
		send_item(31'd1, 16'hFFFF);
		send_item(31'd7, 16'd1);
	endtask

	task automatic test_extremes();
		send_item(31'h7FFFFFFF, 16'd1);
		send_item(31'h7FFFFFFF, 16'd12);
		send_item(31'h7FFFFFFF, 16'd14);
		send_item(31'h7FFFFFFF, 16'hFFFF);
		send_item(31'd2, 16'hFFFF);
		send_item(31'd10, 16'd127);
		send_item(31'd10, 16'd128);
		send_item(31'd2, 16'd422);
		send_item(31'd2, 16'd426);
		send_item(31'd99999, 16'd25);
		send_item(31'd9, 16'd100);
		send_item(31'd1000000000, 16'd3);
	endtask

	task automatic test_random();
		int sel;
		for (int n = 0; n < 80; n++) begin
			calm = (n >= 30 && n < 50);
			sel = $urandom_range(0, 99);
			if (sel < 70)
				send_item(31'($urandom_range(0, 999)), 16'($urandom_range(0, 20)));
			else if (sel < 85)
				send_item(31'($urandom), 16'($urandom_range(0, 3)));
			else if (sel < 95)
				send_item(31'($urandom_range(2, 9999)), 16'($urandom));
			else
				send_item(31'($urandom_range(0, 1)), 16'($urandom));
		end
		calm = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		fail_count = 0;
		idle_cycles = 0;
		calm = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_extremes();
		test_random();
		in_valid <= 1'b0;
		while (group_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS decimal_bignum_power_core");
		else
			$display("FAIL decimal_bignum_power_core");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/dbp_pkg.sv
rtl/decimal_bignum_power_core.sv
test/decimal_bignum_power_core_tb.sv
